/* hdl/rrwl_pkg.sv */
// shared types and codes for the recursive reader-writer lock tracker
package rrwl_pkg;

    // operation kinds
    localparam logic [2:0] KIND_LOCK    = 3'd0;
    localparam logic [2:0] KIND_TRY_EX  = 3'd1;
    localparam logic [2:0] KIND_UNLOCK  = 3'd2;
    localparam logic [2:0] KIND_LOCK_SH = 3'd3;
    localparam logic [2:0] KIND_TRY_SH  = 3'd4;

    // commands to the underlying lock
    localparam logic [2:0] CMD_NONE   = 3'd0;
    localparam logic [2:0] CMD_ACQ_EX = 3'd1;
    localparam logic [2:0] CMD_REL_EX = 3'd2;
    localparam logic [2:0] CMD_ACQ_SH = 3'd3;
    localparam logic [2:0] CMD_REL_SH = 3'd4;

    // result status
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_UNHELD = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;
    localparam logic [1:0] STAT_OVF    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SECOND
    } t_state;

    // table write controls
    typedef struct packed {
        logic wr_en;
        logic set_valid;
        logic clr_valid;
        logic use_free;
    } t_tbl_ctl;

    // first result of a transaction
    typedef struct packed {
        logic [2:0] cmd;
        logic       ok;
        logic [1:0] status;
        logic       two;
    } t_result;

endpackage

/* hdl/rrwl_table.sv */
// lock table storage: id/count memory with registered read, valid bits in flops
module rrwl_table #(
    parameter int TABLE_DEPTH = 16,
    parameter int ID_BITS     = 32,
    parameter int CNT_W       = 9,
    parameter int AW          = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_rd_en,
    input  logic [AW-1:0]           i_rd_addr,
    output logic                    o_rd_valid,
    output logic [ID_BITS-1:0]      o_rd_id,
    output logic signed [CNT_W-1:0] o_rd_cnt,
    input  rrwl_pkg::t_tbl_ctl      i_ctl,
    input  logic [AW-1:0]           i_wr_addr,
    input  logic [ID_BITS-1:0]      i_wr_id,
    input  logic signed [CNT_W-1:0] i_wr_cnt
);

    logic [ID_BITS+CNT_W-1:0] r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]   r_valid;
    logic [ID_BITS+CNT_W-1:0] r_rd_data;
    logic                     r_rd_valid;

    // memory port: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_id, i_wr_cnt};
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.wr_en && i_ctl.set_valid) begin
                r_valid[i_wr_addr] <= 1'b1;
            end else if (i_ctl.wr_en && i_ctl.clr_valid) begin
                r_valid[i_wr_addr] <= 1'b0;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_id    = r_rd_data[ID_BITS+CNT_W-1:CNT_W];
    assign o_rd_cnt   = $signed(r_rd_data[CNT_W-1:0]);

    a_set_clr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.wr_en |-> !(i_ctl.set_valid && i_ctl.clr_valid))
        else $error("table write both sets and clears valid");

endmodule

/* hdl/rrwl_decide.sv */
// update decision for one transaction after the table scan
module rrwl_decide #(
    parameter int CNT_W     = 9,
    parameter int MAX_DEPTH = 255
) (
    input  logic [2:0]              i_kind,
    input  logic                    i_granted,
    input  logic                    i_found,
    input  logic                    i_free_found,
    input  logic signed [CNT_W-1:0] i_hit_cnt,
    output rrwl_pkg::t_result       o_res,
    output rrwl_pkg::t_tbl_ctl      o_ctl,
    output logic signed [CNT_W-1:0] o_cnt
);

    localparam logic signed [CNT_W-1:0] MAX_POS = CNT_W'(MAX_DEPTH);
    localparam logic signed [CNT_W-1:0] MAX_NEG = -MAX_POS;
    localparam logic signed [CNT_W-1:0] ONE     = CNT_W'(1);

    logic signed [CNT_W-1:0] c_dec;
    logic signed [CNT_W-1:0] c_inc;
    logic                    is_try;

    assign c_dec  = i_hit_cnt - ONE;
    assign c_inc  = i_hit_cnt + ONE;
    assign is_try = (i_kind == rrwl_pkg::KIND_TRY_EX) ||
                    (i_kind == rrwl_pkg::KIND_TRY_SH);

    always_comb begin
        o_res = '{cmd: rrwl_pkg::CMD_NONE, ok: 1'b0, status: rrwl_pkg::STAT_OK, two: 1'b0};
        o_ctl = '0;
        o_cnt = '0;
        priority if (i_kind > rrwl_pkg::KIND_TRY_SH) begin
            // unknown kind: empty result
        end else if (!i_found) begin
            priority if (i_kind == rrwl_pkg::KIND_UNLOCK) begin
                o_res.status = rrwl_pkg::STAT_UNHELD;
            end else if (!i_free_found) begin
                o_res.status = rrwl_pkg::STAT_FULL;
            end else if (is_try && !i_granted) begin
                // attempt refused
            end else begin
                o_ctl.wr_en     = 1'b1;
                o_ctl.set_valid = 1'b1;
                o_ctl.use_free  = 1'b1;
                o_res.ok        = 1'b1;
                if (i_kind == rrwl_pkg::KIND_LOCK || i_kind == rrwl_pkg::KIND_TRY_EX) begin
                    o_cnt     = -ONE;
                    o_res.cmd = rrwl_pkg::CMD_ACQ_EX;
                end else begin
                    o_cnt     = ONE;
                    o_res.cmd = rrwl_pkg::CMD_ACQ_SH;
                end
            end
        end else if (i_kind == rrwl_pkg::KIND_UNLOCK) begin
            o_ctl.wr_en = 1'b1;
            o_res.ok    = 1'b1;
            if (i_hit_cnt > 0) begin
                o_cnt = c_dec;
                if (c_dec == 0) begin
                    o_res.cmd = rrwl_pkg::CMD_REL_SH;
                end
            end else begin
                o_cnt = c_inc;
                if (c_inc == 0) begin
                    o_res.cmd = rrwl_pkg::CMD_REL_EX;
                end
            end
            o_ctl.clr_valid = (o_cnt == 0);
        end else if (i_hit_cnt < 0) begin
            // exclusive hold: every acquire deepens it unless the depth is already at MAX_DEPTH
            o_cnt = i_hit_cnt;
            if (i_hit_cnt <= MAX_NEG) begin
                o_res.status = rrwl_pkg::STAT_OVF;
            end else begin
                o_cnt       = c_dec;
                o_ctl.wr_en = 1'b1;
                o_res.ok    = 1'b1;
            end
        end else begin
            // shared hold
            o_cnt = i_hit_cnt;
            priority if (i_kind == rrwl_pkg::KIND_TRY_EX) begin
                // no upgrade on try
            end else if (i_hit_cnt >= MAX_POS) begin
                o_res.status = rrwl_pkg::STAT_OVF;
            end else if (i_kind == rrwl_pkg::KIND_LOCK) begin
                // upgrade: release shared, then acquire exclusive
                o_cnt       = -c_inc;
                o_ctl.wr_en = 1'b1;
                o_res.ok    = 1'b1;
                o_res.cmd   = rrwl_pkg::CMD_REL_SH;
                o_res.two   = 1'b1;
            end else begin
                o_cnt       = c_inc;
                o_ctl.wr_en = 1'b1;
                o_res.ok    = 1'b1;
            end
        end
    end

endmodule

/* hdl/recursive_rw_lock_tracker.sv */
// top level of the recursive reader-writer lock tracker
//
//  channel   signals                                         direction  handshake
//  command   start, i_kind, i_lock_id, i_attempt_granted     in         start & !busy
//  result    o_strobe, o_lock_command, o_succeeded,          out        o_strobe, one cycle
//            o_status, o_hold_count, o_last
//
// the scan reads one table slot a cycle through the single read port; each read
// is registered and checked against the id, and a decide/write-back state then
// issues the (first) result strobe.
// an upgrade adds a second result strobe in the cycle after the first.
// busy is high from the accepting edge until the last result is issued.
// reset is synchronous and active low; it empties the table at once (valid flops).
// results cannot be stalled: each is on the ports for exactly one cycle.
module recursive_rw_lock_tracker #(
    parameter int TABLE_DEPTH = 16,
    parameter int ID_BITS     = 32,
    parameter int MAX_DEPTH   = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_lock_id,
    input  logic        i_attempt_granted,
    output logic        o_strobe,
    output logic [2:0]  o_lock_command,
    output logic        o_succeeded,
    output logic [1:0]  o_status,
    output logic signed [8:0] o_hold_count,
    output logic        o_last
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(MAX_DEPTH + 1) + 1;
    localparam logic [AW:0] SCAN_END = (AW + 1)'(TABLE_DEPTH);

    rrwl_pkg::t_state r_state, n_state;

    // captured transaction
    logic [2:0]         r_kind;
    logic [ID_BITS-1:0] r_id;
    logic               r_granted;
    logic [63:0]        id_ext;
    logic [ID_BITS-1:0] id_in;

    // scan pipeline
    logic [AW:0]   r_scan_cnt;
    logic          r_chk;
    logic [AW-1:0] r_chk_idx;
    logic          rd_en;

    // scan captures
    logic                    r_found;
    logic [AW-1:0]           r_hit_idx;
    logic signed [CNT_W-1:0] r_hit_cnt;
    logic                    r_free_found;
    logic [AW-1:0]           r_free_idx;

    // table read side
    logic                    rd_valid;
    logic [ID_BITS-1:0]      rd_id;
    logic signed [CNT_W-1:0] rd_cnt;
    logic                    hit;

    // decision
    rrwl_pkg::t_result       dec_res;
    rrwl_pkg::t_tbl_ctl      dec_ctl;
    rrwl_pkg::t_tbl_ctl      tbl_ctl;
    logic signed [CNT_W-1:0] dec_cnt;
    logic [AW-1:0]           wr_addr;

    // result registers
    logic        r_strobe, n_strobe;
    logic [2:0]  r_cmd, n_cmd;
    logic        r_ok, n_ok;
    logic [1:0]  r_status, n_status;
    logic [8:0]  r_hold, n_hold;
    logic        r_last, n_last;
    logic [8:0]  r_up_hold;

    logic accept;

    assign accept = start && (r_state == rrwl_pkg::S_IDLE);
    assign busy   = (r_state != rrwl_pkg::S_IDLE);

    // id taken modulo 2^ID_BITS, zero-extended where ID_BITS exceeds the port
    assign id_ext = 64'(i_lock_id);
    assign id_in  = id_ext[ID_BITS-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rrwl_pkg::S_IDLE: begin
                if (start) begin
                    n_state = rrwl_pkg::S_SCAN;
                end
            end
            rrwl_pkg::S_SCAN: begin
                // last slot's data is checked in the cycle the counter hits the end
                if (r_scan_cnt == SCAN_END) begin
                    n_state = rrwl_pkg::S_DECIDE;
                end
            end
            rrwl_pkg::S_DECIDE: begin
                n_state = dec_res.two ? rrwl_pkg::S_SECOND : rrwl_pkg::S_IDLE;
            end
            rrwl_pkg::S_SECOND: begin
                n_state = rrwl_pkg::S_IDLE;
            end
            default: begin
                n_state = rrwl_pkg::S_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb begin
        rd_en    = 1'b0;
        tbl_ctl  = '0;
        n_strobe = 1'b0;
        n_cmd    = r_cmd;
        n_ok     = r_ok;
        n_status = r_status;
        n_hold   = r_hold;
        n_last   = r_last;
        unique case (r_state)
            rrwl_pkg::S_IDLE: begin
            end
            rrwl_pkg::S_SCAN: begin
                rd_en = (r_scan_cnt < SCAN_END);
            end
            rrwl_pkg::S_DECIDE: begin
                tbl_ctl  = dec_ctl;
                n_strobe = 1'b1;
                n_cmd    = dec_res.cmd;
                n_ok     = dec_res.ok;
                n_status = dec_res.status;
                n_hold   = 9'(dec_cnt);
                n_last   = !dec_res.two;
            end
            rrwl_pkg::S_SECOND: begin
                // exclusive acquire half of an upgrade
                n_strobe = 1'b1;
                n_cmd    = rrwl_pkg::CMD_ACQ_EX;
                n_ok     = 1'b1;
                n_status = rrwl_pkg::STAT_OK;
                n_hold   = r_up_hold;
                n_last   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign hit     = r_chk && rd_valid && (rd_id == r_id);
    assign wr_addr = dec_ctl.use_free ? r_free_idx : r_hit_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rrwl_pkg::S_IDLE;
            r_chk    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_chk    <= rd_en;
            r_strobe <= n_strobe;
        end
    end

    // payload and scan bookkeeping
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_ok      <= n_ok;
        r_status  <= n_status;
        r_hold    <= n_hold;
        r_last    <= n_last;
        r_chk_idx <= r_scan_cnt[AW-1:0];
        if (accept) begin
            r_kind       <= i_kind;
            r_id         <= id_in;
            r_granted    <= i_attempt_granted;
            r_scan_cnt   <= '0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            if (rd_en) begin
                r_scan_cnt <= r_scan_cnt + 1'b1;
            end
            // lowest matching slot wins
            if (hit && !r_found) begin
                r_found   <= 1'b1;
                r_hit_idx <= r_chk_idx;
                r_hit_cnt <= rd_cnt;
            end
            // lowest free slot wins
            if (r_chk && !rd_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_chk_idx;
            end
        end
        if (r_state == rrwl_pkg::S_DECIDE) begin
            r_up_hold <= 9'(dec_cnt);
        end
    end

    rrwl_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_BITS     (ID_BITS),
        .CNT_W       (CNT_W),
        .AW          (AW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_scan_cnt[AW-1:0]),
        .o_rd_valid (rd_valid),
        .o_rd_id    (rd_id),
        .o_rd_cnt   (rd_cnt),
        .i_ctl      (tbl_ctl),
        .i_wr_addr  (wr_addr),
        .i_wr_id    (r_id),
        .i_wr_cnt   (dec_cnt)
    );

    rrwl_decide #(
        .CNT_W     (CNT_W),
        .MAX_DEPTH (MAX_DEPTH)
    ) u_decide (
        .i_kind       (r_kind),
        .i_granted    (r_granted),
        .i_found      (r_found),
        .i_free_found (r_free_found),
        .i_hit_cnt    (r_hit_cnt),
        .o_res        (dec_res),
        .o_ctl        (dec_ctl),
        .o_cnt        (dec_cnt)
    );

    assign o_strobe       = r_strobe;
    assign o_lock_command = r_cmd;
    assign o_succeeded    = r_ok;
    assign o_status       = r_status;
    assign o_hold_count   = $signed(r_hold);
    assign o_last         = r_last;

    a_strobe_from_result_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> ($past(r_state) == rrwl_pkg::S_DECIDE ||
                      $past(r_state) == rrwl_pkg::S_SECOND))
        else $error("result strobe outside a result state");

    a_upgrade_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_last) |=> (r_strobe && r_last && r_cmd == rrwl_pkg::CMD_ACQ_EX))
        else $error("upgrade release not followed by exclusive acquire");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy && r_scan_cnt == '0))
        else $error("accepted transaction did not start a scan");

    a_write_only_in_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_ctl.wr_en |-> (r_state == rrwl_pkg::S_DECIDE && !rd_en))
        else $error("table write outside the decide cycle");

endmodule
